// ===== hdl/ejm_pkg.sv =====
// Shared types, constants and character tables for the EUC-JP to ISO-2022-JP
// MIME encoder. No dependencies; every other file of the block uses it.
package ejm_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW = $clog2(QDEPTH);

   localparam logic [6:0] LIMIT_RESET = 7'd64;
   localparam logic [6:0] LIMIT_MIN = 7'd8;

   localparam logic [7:0] LEAD_LO = 8'ha1;
   localparam logic [7:0] LEAD_HI = 8'hfe;
   localparam logic [7:0] MASK7 = 8'h7f;

   localparam logic [7:0] CH_ESC = 8'h1b;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_UB = 8'h42;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_UJ = 8'h4a;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_EQ = 8'h3d;
   localparam logic [7:0] CH_QM = 8'h3f;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   // Header sequence: TAB SPACE "=?ISO-2022-jp?B?"
   localparam logic [4:0] HDR_FIRST = 5'd0;
   localparam logic [4:0] HDR_NOSEP = 5'd2;
   localparam logic [4:0] HDR_LAST = 5'd17;

   // Close sequence: up to four base64 characters, "?=", CR LF
   localparam logic [2:0] CLS_B64 = 3'd0;
   localparam logic [2:0] CLS_TAIL = 3'd4;
   localparam logic [2:0] CLS_END_NOCRLF = 3'd5;
   localparam logic [2:0] CLS_END_CRLF = 3'd7;

   localparam logic [1:0] CSR_LIMIT = 2'd0;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       end_of_run;
      logic       end_of_message;
   } rsp_type;

   // One classified request handed from the front to the back.
   typedef struct packed {
      logic       is_kanji;
      logic [7:0] lead;
      logic [7:0] trail;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type data;
   } qwr_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      cmd_type data;
   } qstat_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_PUT,
      B_HDR,
      B_B64,
      B_CLOSE
   } bstate_type;

   typedef enum logic [4:0] {
      ACT_KESC0,
      ACT_KESC1,
      ACT_KESC2,
      ACT_LEAD,
      ACT_TRAIL,
      ACT_XESC0,
      ACT_XESC1,
      ACT_XESC2,
      ACT_CLOSE,
      ACT_PESC0,
      ACT_PESC1,
      ACT_PESC2,
      ACT_BYTE,
      ACT_LESC0,
      ACT_LESC1,
      ACT_LESC2,
      ACT_LCLOSE,
      ACT_DONE
   } act_type;

   function automatic logic [7:0] hdr_char(input logic [4:0] idx);
      logic [7:0] c;
      unique case (idx)
         5'd0: c = CH_TAB;
         5'd1: c = CH_SPACE;
         5'd2: c = CH_EQ;
         5'd3: c = CH_QM;
         5'd4: c = 8'h49;
         5'd5: c = 8'h53;
         5'd6: c = 8'h4f;
         5'd7: c = 8'h2d;
         5'd8: c = 8'h32;
         5'd9: c = 8'h30;
         5'd10: c = 8'h32;
         5'd11: c = 8'h32;
         5'd12: c = 8'h2d;
         5'd13: c = 8'h6a;
         5'd14: c = 8'h70;
         5'd15: c = CH_QM;
         5'd16: c = CH_UB;
         5'd17: c = CH_QM;
         default: c = CH_QM;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v < 6'd26) begin
         c = 8'h41 + w;
      end else if (v < 6'd52) begin
         c = 8'h47 + w;
      end else if (v < 6'd62) begin
         c = w - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

endpackage

// ===== hdl/ejm_csr.sv =====
// Configuration register file of the encoder: the chunk limit register
// behind an APB-style port. Depends on ejm_pkg.
module ejm_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [6:0]  chunk_limit
);

   logic [6:0] limit_ff;
   logic [6:0] limit_in;
   logic       wr_en;
   logic       sel_limit;

   assign csr_pready = 1'b1;
   assign sel_limit = ({1'b0, csr_paddr[2]} == ejm_pkg::CSR_LIMIT);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && sel_limit;

   always_comb begin
      limit_in = limit_ff;
      if (wr_en) begin
         limit_in = csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ejm_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign csr_prdata = sel_limit ? {25'd0, limit_ff} : 32'd0;
   assign chunk_limit = limit_ff;

endmodule

// ===== hdl/ejm_front.sv =====
// Front end of the encoder: accepts EUC-JP bytes, pairs kanji lead and trail
// bytes and pushes one classified request per plain byte or pair. Uses ejm_pkg.
module ejm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ejm_pkg::req_type  req_payload,
   input  logic              q_full,
   output ejm_pkg::qwr_type  q_wr
);

   logic       pend_ff;
   logic       pend_in;
   logic [7:0] lead_ff;
   logic [7:0] lead_in;
   logic       accept;
   logic       is_lead;

   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;
   assign is_lead = (req_payload.in_byte >= ejm_pkg::LEAD_LO) &&
                    (req_payload.in_byte <= ejm_pkg::LEAD_HI);

   always_comb begin
      pend_in = pend_ff;
      lead_in = lead_ff;
      q_wr.push = 1'b0;
      q_wr.data.is_kanji = 1'b0;
      q_wr.data.lead = req_payload.in_byte;
      q_wr.data.trail = 8'd0;
      q_wr.data.last = req_payload.last;
      if (accept) begin
         if (pend_ff) begin
            // Any byte after a held lead is its trail byte.
            pend_in = 1'b0;
            q_wr.push = 1'b1;
            q_wr.data.is_kanji = 1'b1;
            q_wr.data.lead = lead_ff;
            q_wr.data.trail = req_payload.in_byte;
         end else if (is_lead && !req_payload.last) begin
            pend_in = 1'b1;
            lead_in = req_payload.in_byte;
         end else if (is_lead) begin
            // A lead byte that ends the message is paired with zero.
            q_wr.push = 1'b1;
            q_wr.data.is_kanji = 1'b1;
         end else begin
            q_wr.push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff <= lead_in;
   end

endmodule

// ===== hdl/ejm_queue.sv =====
// Short request queue between the front and the back of the encoder.
// Register-based FIFO of ejm_pkg::QDEPTH entries. Uses ejm_pkg.
module ejm_queue (
   input  logic               clock,
   input  logic               reset,
   input  ejm_pkg::qwr_type   q_wr,
   input  logic               q_pop,
   output ejm_pkg::qstat_type q_stat
);

   ejm_pkg::cmd_type          mem_ff [ejm_pkg::QDEPTH];
   logic [ejm_pkg::QAW:0]     wr_ptr_ff;
   logic [ejm_pkg::QAW:0]     wr_ptr_in;
   logic [ejm_pkg::QAW:0]     rd_ptr_ff;
   logic [ejm_pkg::QAW:0]     rd_ptr_in;
   logic                      full;
   logic                      empty;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full = (wr_ptr_ff[ejm_pkg::QAW] != rd_ptr_ff[ejm_pkg::QAW]) &&
                 (wr_ptr_ff[ejm_pkg::QAW-1:0] == rd_ptr_ff[ejm_pkg::QAW-1:0]);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (q_wr.push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push && !full) begin
         mem_ff[wr_ptr_ff[ejm_pkg::QAW-1:0]] <= q_wr.data;
      end
   end

   assign q_stat.empty = empty;
   assign q_stat.full = full;
   assign q_stat.data = mem_ff[rd_ptr_ff[ejm_pkg::QAW-1:0]];

endmodule

// ===== hdl/ejm_back.sv =====
// Back end of the encoder: turns requests into JIS bytes, chunks them,
// base64-encodes and frames each chunk, one character per cycle while the
// output does not stall, with a hold stage and an output register. Uses ejm_pkg.
module ejm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [6:0]         chunk_limit,
   input  ejm_pkg::qstat_type q_stat,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ejm_pkg::rsp_type   rsp_payload
);

   ejm_pkg::bstate_type state_ff, state_in;
   ejm_pkg::act_type    act_ff, act_in;
   ejm_pkg::act_type    nxt;
   ejm_pkg::cmd_type    cmd_ff, cmd_in;
   logic [4:0]          hidx_ff, hidx_in;
   logic [1:0]          bidx_ff, bidx_in;
   logic [2:0]          cidx_ff, cidx_in;
   logic                kmode_ff, kmode_in;
   logic [7:0]          count_ff, count_in;
   logic                open_ff, open_in;
   logic                notfirst_ff, notfirst_in;
   logic [15:0]         carry_ff, carry_in;
   logic [1:0]          ccnt_ff, ccnt_in;

   logic                hold_valid_ff, hold_valid_in;
   logic [7:0]          hold_char_ff, hold_char_in;
   logic                hold_final_ff, hold_final_in;
   logic                hold_eom_ff, hold_eom_in;
   logic                out_valid_ff, out_valid_in;
   ejm_pkg::rsp_type    out_ff, out_in;

   logic [6:0]          eff_limit;
   logic [7:0]          jb;
   logic [7:0]          emit_char;
   logic [7:0]          close_char;
   logic [2:0]          close_end;
   logic                emit;
   logic                adv;
   logic                done;
   logic                out_free;
   logic                stall;
   logic                move;
   logic                over;

   function automatic ejm_pkg::act_type next_act(input ejm_pkg::act_type a,
                                                 input logic ovr,
                                                 input logic fin);
      ejm_pkg::act_type n;
      unique case (a)
         ejm_pkg::ACT_KESC0: n = ejm_pkg::ACT_KESC1;
         ejm_pkg::ACT_KESC1: n = ejm_pkg::ACT_KESC2;
         ejm_pkg::ACT_KESC2: n = ejm_pkg::ACT_LEAD;
         ejm_pkg::ACT_LEAD: n = ejm_pkg::ACT_TRAIL;
         ejm_pkg::ACT_TRAIL: n = ovr ? ejm_pkg::ACT_XESC0 :
                                 (fin ? ejm_pkg::ACT_LESC0 : ejm_pkg::ACT_DONE);
         ejm_pkg::ACT_XESC0: n = ejm_pkg::ACT_XESC1;
         ejm_pkg::ACT_XESC1: n = ejm_pkg::ACT_XESC2;
         ejm_pkg::ACT_XESC2: n = ejm_pkg::ACT_CLOSE;
         ejm_pkg::ACT_CLOSE: n = fin ? ejm_pkg::ACT_LESC0 : ejm_pkg::ACT_DONE;
         ejm_pkg::ACT_PESC0: n = ejm_pkg::ACT_PESC1;
         ejm_pkg::ACT_PESC1: n = ejm_pkg::ACT_PESC2;
         ejm_pkg::ACT_PESC2: n = ejm_pkg::ACT_BYTE;
         ejm_pkg::ACT_BYTE: n = ovr ? ejm_pkg::ACT_CLOSE :
                                (fin ? ejm_pkg::ACT_LESC0 : ejm_pkg::ACT_DONE);
         ejm_pkg::ACT_LESC0: n = ejm_pkg::ACT_LESC1;
         ejm_pkg::ACT_LESC1: n = ejm_pkg::ACT_LESC2;
         ejm_pkg::ACT_LESC2: n = ejm_pkg::ACT_LCLOSE;
         ejm_pkg::ACT_LCLOSE: n = ejm_pkg::ACT_DONE;
         default: n = ejm_pkg::ACT_DONE;
      endcase
      return n;
   endfunction

   assign eff_limit = (chunk_limit < ejm_pkg::LIMIT_MIN) ? ejm_pkg::LIMIT_MIN : chunk_limit;

   // JIS byte that the current action puts into the chunk.
   always_comb begin
      unique case (act_ff)
         ejm_pkg::ACT_KESC0, ejm_pkg::ACT_XESC0,
         ejm_pkg::ACT_PESC0, ejm_pkg::ACT_LESC0: jb = ejm_pkg::CH_ESC;
         ejm_pkg::ACT_KESC1: jb = ejm_pkg::CH_DOLLAR;
         ejm_pkg::ACT_KESC2: jb = ejm_pkg::CH_UB;
         ejm_pkg::ACT_XESC1, ejm_pkg::ACT_PESC1,
         ejm_pkg::ACT_LESC1: jb = ejm_pkg::CH_LPAREN;
         ejm_pkg::ACT_XESC2, ejm_pkg::ACT_PESC2,
         ejm_pkg::ACT_LESC2: jb = ejm_pkg::CH_UJ;
         ejm_pkg::ACT_LEAD: jb = cmd_ff.lead & ejm_pkg::MASK7;
         ejm_pkg::ACT_TRAIL: jb = cmd_ff.trail & ejm_pkg::MASK7;
         ejm_pkg::ACT_BYTE: jb = cmd_ff.lead;
         default: jb = 8'd0;
      endcase
   end

   // Characters that close a chunk: base64 remainder with padding, then "?=", then CR LF.
   always_comb begin
      close_char = ejm_pkg::CH_EQ;
      case (cidx_ff)
         3'd0: close_char = (ccnt_ff == 2'd1) ? ejm_pkg::b64_char(carry_ff[7:2]) :
                                               ejm_pkg::b64_char(carry_ff[15:10]);
         3'd1: close_char = (ccnt_ff == 2'd1) ?
                            ejm_pkg::b64_char({carry_ff[1:0], 4'd0}) :
                            ejm_pkg::b64_char(carry_ff[9:4]);
         3'd2: close_char = (ccnt_ff == 2'd1) ? ejm_pkg::CH_EQ :
                            ejm_pkg::b64_char({carry_ff[3:0], 2'd0});
         3'd3: close_char = ejm_pkg::CH_EQ;
         3'd4: close_char = ejm_pkg::CH_QM;
         3'd5: close_char = ejm_pkg::CH_EQ;
         3'd6: close_char = ejm_pkg::CH_CR;
         default: close_char = ejm_pkg::CH_LF;
      endcase
   end

   assign close_end = (act_ff == ejm_pkg::ACT_LCLOSE) ? ejm_pkg::CLS_END_NOCRLF :
                                                        ejm_pkg::CLS_END_CRLF;
   assign out_free = !out_valid_ff || rsp_ready;
   assign stall = hold_valid_ff && !out_free;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      cmd_in = cmd_ff;
      hidx_in = hidx_ff;
      bidx_in = bidx_ff;
      cidx_in = cidx_ff;
      kmode_in = kmode_ff;
      count_in = count_ff;
      open_in = open_ff;
      notfirst_in = notfirst_ff;
      carry_in = carry_ff;
      ccnt_in = ccnt_ff;
      emit = 1'b0;
      emit_char = 8'd0;
      adv = 1'b0;
      done = 1'b0;
      q_pop = 1'b0;
      nxt = ejm_pkg::ACT_DONE;
      over = 1'b0;

      unique case (state_ff)
         ejm_pkg::B_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               cmd_in = q_stat.data;
               state_in = ejm_pkg::B_PUT;
               if (q_stat.data.is_kanji) begin
                  act_in = kmode_ff ? ejm_pkg::ACT_LEAD : ejm_pkg::ACT_KESC0;
                  kmode_in = 1'b1;
               end else begin
                  act_in = kmode_ff ? ejm_pkg::ACT_PESC0 : ejm_pkg::ACT_BYTE;
                  kmode_in = 1'b0;
               end
            end
         end
         ejm_pkg::B_PUT: begin
            if (!open_ff) begin
               hidx_in = notfirst_ff ? ejm_pkg::HDR_FIRST : ejm_pkg::HDR_NOSEP;
               state_in = ejm_pkg::B_HDR;
            end else if (ccnt_ff < 2'd2) begin
               carry_in = {carry_ff[7:0], jb};
               ccnt_in = ccnt_ff + 2'd1;
               count_in = count_ff + 8'd1;
               adv = 1'b1;
            end else begin
               bidx_in = 2'd0;
               state_in = ejm_pkg::B_B64;
            end
         end
         ejm_pkg::B_HDR: begin
            if (!stall) begin
               emit = 1'b1;
               emit_char = ejm_pkg::hdr_char(hidx_ff);
               if (hidx_ff == ejm_pkg::HDR_LAST) begin
                  open_in = 1'b1;
                  state_in = ejm_pkg::B_PUT;
               end else begin
                  hidx_in = hidx_ff + 5'd1;
               end
            end
         end
         ejm_pkg::B_B64: begin
            if (!stall) begin
               emit = 1'b1;
               case (bidx_ff)
                  2'd0: emit_char = ejm_pkg::b64_char(carry_ff[15:10]);
                  2'd1: emit_char = ejm_pkg::b64_char(carry_ff[9:4]);
                  2'd2: emit_char = ejm_pkg::b64_char({carry_ff[3:0], jb[7:6]});
                  default: emit_char = ejm_pkg::b64_char(jb[5:0]);
               endcase
               if (bidx_ff == 2'd3) begin
                  carry_in = 16'd0;
                  ccnt_in = 2'd0;
                  count_in = count_ff + 8'd1;
                  adv = 1'b1;
               end else begin
                  bidx_in = bidx_ff + 2'd1;
               end
            end
         end
         ejm_pkg::B_CLOSE: begin
            if (!stall) begin
               emit = 1'b1;
               emit_char = close_char;
               if (cidx_ff == close_end) begin
                  adv = 1'b1;
                  carry_in = 16'd0;
                  ccnt_in = 2'd0;
                  count_in = 8'd0;
                  open_in = 1'b0;
                  kmode_in = 1'b0;
                  // The final close starts the next message from scratch.
                  notfirst_in = (act_ff != ejm_pkg::ACT_LCLOSE);
               end else begin
                  cidx_in = cidx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ejm_pkg::B_IDLE;
         end
      endcase

      if (adv) begin
         over = (count_in > {1'b0, eff_limit});
         nxt = next_act(act_ff, over, cmd_ff.last);
         act_in = nxt;
         if (nxt == ejm_pkg::ACT_DONE) begin
            state_in = ejm_pkg::B_IDLE;
            done = 1'b1;
         end else if (nxt == ejm_pkg::ACT_CLOSE || nxt == ejm_pkg::ACT_LCLOSE) begin
            state_in = ejm_pkg::B_CLOSE;
            cidx_in = (ccnt_in == 2'd0) ? ejm_pkg::CLS_TAIL : ejm_pkg::CLS_B64;
         end else begin
            state_in = ejm_pkg::B_PUT;
         end
      end
   end

   // The newest character waits in the hold stage until the next one is
   // known or its request is finished, so that end_of_run can be marked.
   assign move = hold_valid_ff && out_free && (emit || hold_final_ff);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      hold_valid_in = hold_valid_ff;
      hold_char_in = hold_char_ff;
      hold_final_in = hold_final_ff;
      hold_eom_in = hold_eom_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_in.out_char = hold_char_ff;
         out_in.end_of_run = hold_final_ff;
         out_in.end_of_message = hold_eom_ff;
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         hold_valid_in = 1'b1;
         hold_char_in = emit_char;
         hold_final_in = done;
         hold_eom_in = done && cmd_ff.last;
      end else if (move) begin
         hold_valid_in = 1'b0;
      end else if (done && hold_valid_ff && !hold_final_ff) begin
         hold_final_in = 1'b1;
         hold_eom_in = cmd_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ejm_pkg::B_IDLE;
         act_ff <= ejm_pkg::ACT_DONE;
         kmode_ff <= 1'b0;
         count_ff <= 8'd0;
         open_ff <= 1'b0;
         notfirst_ff <= 1'b0;
         carry_ff <= 16'd0;
         ccnt_ff <= 2'd0;
         hold_valid_ff <= 1'b0;
         hold_final_ff <= 1'b0;
         hold_eom_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         act_ff <= act_in;
         kmode_ff <= kmode_in;
         count_ff <= count_in;
         open_ff <= open_in;
         notfirst_ff <= notfirst_in;
         carry_ff <= carry_in;
         ccnt_ff <= ccnt_in;
         hold_valid_ff <= hold_valid_in;
         hold_final_ff <= hold_final_in;
         hold_eom_ff <= hold_eom_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      hidx_ff <= hidx_in;
      bidx_ff <= bidx_in;
      cidx_ff <= cidx_in;
      hold_char_ff <= hold_char_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== hdl/euc_to_iso2022jp_mime_encoder.sv =====
// Top level of the EUC-JP to ISO-2022-JP MIME B encoded-word encoder.
// Instantiates ejm_csr, ejm_front, ejm_queue and ejm_back; uses ejm_pkg.
//
// The block takes one EUC-JP byte per request and delivers the encoded header
// text one ASCII character per response, marking the last character caused by
// each request and the final character of the message. The front pairs kanji
// bytes and accepts a byte in every cycle while its four-entry queue has room;
// the back takes a request from the queue, places each JIS byte into the
// chunk, and emits the output characters one by one (16 for the first chunk
// header of a message, 18 for a later one, four per base64 group, up to eight
// to close a chunk). A lead byte not marked last produces no response.
// chunk_limit (reset 64; values below 8 act as 8) is written through the csr
// port at address 0.
module euc_to_iso2022jp_mime_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ejm_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ejm_pkg::rsp_type  rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic               [6:0] chunk_limit;
   ejm_pkg::qwr_type   q_wr;
   ejm_pkg::qstat_type q_stat;
   logic               q_pop;

   ejm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .chunk_limit (chunk_limit)
   );

   ejm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_stat.full),
      .q_wr        (q_wr)
   );

   ejm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_pop  (q_pop),
      .q_stat (q_stat)
   );

   ejm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .chunk_limit (chunk_limit),
      .q_stat      (q_stat),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sim/euc_to_iso2022jp_mime_encoder_tb.sv =====
// Self-checking testbench for euc_to_iso2022jp_mime_encoder: directed and random
// EUC-JP messages go in, the MIME header characters coming out are checked against
// a local predictor. Depends on ejm_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module euc_to_iso2022jp_mime_encoder_tb;
   import ejm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   euc_to_iso2022jp_mime_encoder uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   req_type request_queue[$];
   rsp_type expected_chars[$];
   rsp_type step_out[$];

   string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   string word_header = "=?ISO-2022-jp?B?";

   // Predictor copy of the encoder state and its chunk limit register.
   logic [6:0] cfg_limit = LIMIT_RESET;
   logic enc_kanji = 1'b0;
   logic [7:0] enc_lead = '0;
   logic enc_held = 1'b0;
   int enc_count = 0;
   logic enc_open = 1'b0;
   logic enc_more = 1'b0;
   logic [15:0] enc_carry = '0;
   int enc_carry_n = 0;

   int fault_count = 0;
   int requests = 0;
   int responses = 0;
   int messages_seen = 0;
   int chunks_closed = 0;
   int queued_items = 0;
   int cycle_count = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_hold = 0;
   int rsp_calm = 0;

   function automatic void put_char(input logic [7:0] c);
      rsp_type r;
      r.out_char = c;
      r.end_of_run = 1'b0;
      r.end_of_message = 1'b0;
      step_out.push_back(r);
   endfunction

   function automatic void put_b64(input logic [5:0] v);
      put_char(b64_alphabet[v]);
   endfunction

   // Appends one JIS byte, opening a chunk first if none is open.
   function automatic void add_jis(input logic [7:0] b);
      logic [23:0] grp;
      int i;
      if (!enc_open) begin
         if (enc_more) begin
            put_char(CH_TAB);
            put_char(CH_SPACE);
         end
         for (i = 0; i < word_header.len(); i++)
            put_char(word_header[i]);
         enc_open = 1'b1;
      end
      if (enc_carry_n < 2) begin
         enc_carry = {enc_carry[7:0], b};
         enc_carry_n++;
      end else begin
         grp = {enc_carry, b};
         put_b64(grp[23:18]);
         put_b64(grp[17:12]);
         put_b64(grp[11:6]);
         put_b64(grp[5:0]);
         enc_carry = '0;
         enc_carry_n = 0;
      end
      enc_count++;
   endfunction

   function automatic void add_plain_escape();
      add_jis(CH_ESC);
      add_jis(CH_LPAREN);
      add_jis(CH_UJ);
   endfunction

   function automatic void close_chunk(input logic with_crlf);
      logic [23:0] grp;
      if (enc_carry_n == 1) begin
         grp = {enc_carry[7:0], 16'h0000};
         put_b64(grp[23:18]);
         put_b64(grp[17:12]);
         put_char(CH_EQ);
         put_char(CH_EQ);
      end else if (enc_carry_n == 2) begin
         grp = {enc_carry, 8'h00};
         put_b64(grp[23:18]);
         put_b64(grp[17:12]);
         put_b64(grp[11:6]);
         put_char(CH_EQ);
      end
      put_char(CH_QM);
      put_char(CH_EQ);
      if (with_crlf) begin
         put_char(CH_CR);
         put_char(CH_LF);
      end
      enc_carry = '0;
      enc_carry_n = 0;
      enc_count = 0;
      enc_open = 1'b0;
      enc_more = 1'b1;
      chunks_closed++;
   endfunction

   function automatic void add_kanji(input logic [7:0] lead, input logic [7:0] trail,
                                     input int lim);
      if (!enc_kanji) begin
         add_jis(CH_ESC);
         add_jis(CH_DOLLAR);
         add_jis(CH_UB);
         enc_kanji = 1'b1;
      end
      add_jis(lead & MASK7);
      add_jis(trail & MASK7);
      // A kanji chunk is switched back to plain text before it closes.
      if (enc_count > lim) begin
         add_plain_escape();
         close_chunk(1'b1);
         enc_kanji = 1'b0;
      end
   endfunction

   function automatic void add_plain(input logic [7:0] b, input int lim);
      if (enc_kanji) begin
         add_plain_escape();
         enc_kanji = 1'b0;
      end
      add_jis(b);
      if (enc_count > lim)
         close_chunk(1'b1);
   endfunction

   // Works out every character one request causes and queues them as expected.
   function automatic void predict_request(input req_type rq);
      int lim;
      rsp_type tail;
      lim = (cfg_limit < LIMIT_MIN) ? int'(LIMIT_MIN) : int'(cfg_limit);
      step_out.delete();
      if (enc_held) begin
         enc_held = 1'b0;
         add_kanji(enc_lead, rq.in_byte, lim);
      end else if (rq.in_byte >= LEAD_LO && rq.in_byte <= LEAD_HI) begin
         if (rq.last) begin
            add_kanji(rq.in_byte, 8'h00, lim);
         end else begin
            enc_lead = rq.in_byte;
            enc_held = 1'b1;
         end
      end else begin
         add_plain(rq.in_byte, lim);
      end
      if (rq.last) begin
         add_plain_escape();
         close_chunk(1'b0);
         enc_kanji = 1'b0;
         enc_lead = '0;
         enc_held = 1'b0;
         enc_count = 0;
         enc_open = 1'b0;
         enc_more = 1'b0;
         enc_carry = '0;
         enc_carry_n = 0;
      end
      if (step_out.size() > 0) begin
         tail = step_out.pop_back();
         tail.end_of_run = 1'b1;
         tail.end_of_message = rq.last;
         step_out.push_back(tail);
      end
      foreach (step_out[i])
         expected_chars.push_back(step_out[i]);
   endfunction

   // Wait before the next item or response: mostly random, with calm stretches of none.
   function automatic int draw_pause(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic void note_fault(input string what);
      if (fault_count < MAX_REPORTS)
         $display("[%0t] %s", $realtime, what);
      fault_count++;
   endfunction

   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_request(req_payload);
            requests++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (request_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_payload <= request_queue.pop_front();
               req_gap <= draw_pause(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      rsp_type want;
      int pause;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         responses++;
         if (rsp_payload.end_of_message)
            messages_seen++;
         if (expected_chars.size() == 0) begin
            note_fault($sformatf("unexpected response: char %02h run %0b msg %0b",
                                 rsp_payload.out_char, rsp_payload.end_of_run,
                                 rsp_payload.end_of_message));
         end else begin
            want = expected_chars.pop_front();
            if (want.out_char !== rsp_payload.out_char
                || want.end_of_run !== rsp_payload.end_of_run
                || want.end_of_message !== rsp_payload.end_of_message)
               note_fault($sformatf(
                  "response %0d: expected char %02h run %0b msg %0b, got %02h %0b %0b",
                  responses, want.out_char, want.end_of_run, want.end_of_message,
                  rsp_payload.out_char, rsp_payload.end_of_run,
                  rsp_payload.end_of_message));
         end
         pause = draw_pause(rsp_calm);
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold <= pause - 1;
         end
      end else if (!rsp_ready) begin
         if (rsp_hold == 0)
            rsp_ready <= 1'b1;
         else
            rsp_hold <= rsp_hold - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still expected",
                  cycle_count, expected_chars.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic is_last);
      req_type r;
      r.in_byte = b;
      r.last = is_last;
      request_queue.push_back(r);
      queued_items++;
   endtask

   // Blocks until every request is taken and answered, then lets the block drain.
   task automatic settle();
      while (request_queue.size() != 0 || req_valid || expected_chars.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_limit(input logic [6:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * CSR_LIMIT);
      csr_pwdata <= {25'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cfg_limit = value;
   endtask

   // One phase: a new chunk limit, then random messages that each end on a last byte.
   task automatic run_phase(input logic [6:0] lim, input int budget);
      int start;
      int tokens;
      int t;
      int pick;
      settle();
      write_limit(lim);
      @(negedge clock);
      start = queued_items;
      while (queued_items - start < budget) begin
         tokens = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 10);
         for (t = 0; t < tokens; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 60) begin
               queue_byte(8'($urandom_range(LEAD_LO, LEAD_HI)), 1'b0);
               queue_byte(8'($urandom_range(LEAD_LO, LEAD_HI)), 1'b0);
            end else begin
               queue_byte(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
            end
         end
         case ($urandom_range(0, 3))
            0: begin
               queue_byte(8'($urandom_range(LEAD_LO, LEAD_HI)), 1'b0);
               queue_byte(8'($urandom_range(LEAD_LO, LEAD_HI)), 1'b1);
            end
            1: queue_byte(8'($urandom_range(LEAD_LO, LEAD_HI)), 1'b1);
            2: queue_byte(8'($urandom_range(8'h20, 8'h7e)), 1'b1);
            default: queue_byte(8'($urandom_range(0, 255)), 1'b1);
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed messages at the reset limit: byte extremes, the kana byte passed
      // through, trail bytes of any value, and a lead byte that ends a message.
      @(negedge clock);
      queue_byte(8'h41, 1'b1);
      queue_byte(8'h00, 1'b0); queue_byte(8'h7f, 1'b0); queue_byte(8'h8e, 1'b0);
      queue_byte(8'ha0, 1'b0); queue_byte(8'hff, 1'b1);
      queue_byte(8'ha1, 1'b0); queue_byte(8'ha1, 1'b0);
      queue_byte(8'hfe, 1'b0); queue_byte(8'hfe, 1'b0);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'hb0, 1'b0); queue_byte(8'h00, 1'b0);
      queue_byte(8'hc8, 1'b0); queue_byte(8'hff, 1'b1);
      queue_byte(8'ha4, 1'b1);
      queue_byte(8'h31, 1'b0); queue_byte(8'ha4, 1'b1);
      queue_byte(8'ha1, 1'b0); queue_byte(8'ha1, 1'b0); queue_byte(8'hd2, 1'b1);

      run_phase(7'd8, 30);
      run_phase(7'd100, 60);
      run_phase(7'd3, 30);
      run_phase(LIMIT_RESET, 30);
      run_phase(7'($urandom_range(9, 99)), 30);
      run_phase(7'd8, 20);
      settle();

      $display("covered %0d requests in %0d messages, %0d response characters, %0d chunks",
               requests, messages_seen, responses, chunks_closed);
      $display("chunk limits 3 (clamped), 8, 64, 100 and one random; %0d faults", fault_count);
      if (fault_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ejm_pkg.sv
hdl/ejm_csr.sv
hdl/ejm_front.sv
hdl/ejm_queue.sv
hdl/ejm_back.sv
hdl/euc_to_iso2022jp_mime_encoder.sv
sim/euc_to_iso2022jp_mime_encoder_tb.sv
